// ===== rtl/ipdfx_pkg.sv =====
// Package for the IPD frame extractor: result item type and status codes.
// No dependencies; imported by every module of the block.
package ipdfx_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 16;
    localparam int HCNT_W = 6;

    localparam logic [1:0] ST_PAYLOAD   = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [DATA_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [DATA_W-1:0] CH_I     = 8'h49;
    localparam logic [DATA_W-1:0] CH_P     = 8'h50;
    localparam logic [DATA_W-1:0] CH_D     = 8'h44;
    localparam logic [DATA_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;
    localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [DATA_W-1:0] payload_byte;
        logic              is_last;
        logic [1:0]        status;
    } res_t;

endpackage

// ===== rtl/ipdfx_parser.sv =====
// Byte parser of the IPD frame extractor: header state machine and counters.
// Depends on ipdfx_pkg.
module ipdfx_parser
    import ipdfx_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [DATA_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  max_packet_bytes,
    output logic              res_valid,
    output res_t              res
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_PLUS, PH_I, PH_P, PH_COMMA, PH_DIGITS, PH_SKIP, PH_PAYLOAD
    } phase_t;

    localparam logic [HCNT_W:0] HDR_MAX = (HCNT_W+1)'(MAX_HEADER_BYTES);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    acc_reg, acc_next;
    logic [LEN_W-1:0]    remain_reg, remain_next;
    logic [HCNT_W-1:0]   hcnt_reg, hcnt_next;

    logic [HCNT_W:0]     n;
    logic                digit;
    logic                is_plus;
    logic [LEN_W+3:0]    acc_mul;
    logic [LEN_W:0]      total;

    assign n       = {1'b0, hcnt_reg} + (HCNT_W+1)'(1);
    assign digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_plus = (data_byte == CH_PLUS);
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {12'd0, data_byte - CH_ZERO};
    assign total   = {1'b0, acc_reg} + {{(LEN_W-HCNT_W){1'b0}}, n};

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        hcnt_next   = hcnt_reg;
        res_valid   = 1'b0;
        res         = '{frame_length: '0, payload_byte: '0, is_last: 1'b0,
                        status: ST_REJECT};

        case (phase_reg)
            PH_HUNT:
            begin
                if (is_plus)
                begin
                    phase_next = PH_PLUS;
                    hcnt_next  = HCNT_W'(1);
                end
            end
            PH_PLUS, PH_I, PH_P:
            begin
                if ((phase_reg == PH_PLUS && data_byte == CH_I) ||
                    (phase_reg == PH_I && data_byte == CH_P) ||
                    (phase_reg == PH_P && data_byte == CH_D))
                begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                    hcnt_next  = HCNT_W'(phase_reg + 3'd1);
                end
                else
                begin
                    res_valid = 1'b0;
                    phase_next = is_plus ? PH_PLUS : PH_HUNT;
                    hcnt_next  = is_plus ? HCNT_W'(1) : '0;
                    acc_next   = '0;
                    remain_next = '0;
                end
            end
            PH_COMMA:
            begin
                if (data_byte != CH_COMMA)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    phase_next = PH_DIGITS;
                    hcnt_next  = HCNT_W'(5);
                    acc_next   = '0;
                end
            end
            PH_DIGITS, PH_SKIP:
            begin
                if (n > HDR_MAX)
                begin
                    res_valid = 1'b1;
                end
                else if (phase_reg == PH_DIGITS && digit)
                begin
                    acc_next  = (acc_mul[LEN_W+3:LEN_W] != '0) ? '1 : acc_mul[LEN_W-1:0];
                    hcnt_next = n[HCNT_W-1:0];
                end
                else if (phase_reg == PH_DIGITS && hcnt_reg <= HCNT_W'(5))
                begin
                    res_valid = 1'b1;
                end
                else if (data_byte == CH_COLON)
                begin
                    hcnt_next = n[HCNT_W-1:0];
                    if (acc_reg == '0)
                    begin
                        res_valid = 1'b1;
                    end
                    else if (total > {1'b0, max_packet_bytes})
                    begin
                        res_valid        = 1'b1;
                        res.status       = ST_TOO_LARGE;
                        res.frame_length = acc_reg;
                    end
                    else
                    begin
                        remain_next = acc_reg;
                        phase_next  = PH_PAYLOAD;
                    end
                end
                else
                begin
                    phase_next = PH_SKIP;
                    hcnt_next  = n[HCNT_W-1:0];
                end
            end
            default:
            begin
                res_valid        = 1'b1;
                res.status       = ST_PAYLOAD;
                res.payload_byte = data_byte;
                res.frame_length = acc_reg;
                if (remain_reg <= LEN_W'(1))
                begin
                    res.is_last = 1'b1;
                    phase_next  = PH_HUNT;
                    hcnt_next   = '0;
                    acc_next    = '0;
                    remain_next = '0;
                end
                else
                begin
                    remain_next = remain_reg - LEN_W'(1);
                end
            end
        endcase

        // restart the hunt after any status item
        if (res_valid && res.status != ST_PAYLOAD)
        begin
            phase_next  = is_plus ? PH_PLUS : PH_HUNT;
            hcnt_next   = is_plus ? HCNT_W'(1) : '0;
            acc_next    = '0;
            remain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            acc_reg    <= '0;
            remain_reg <= '0;
            hcnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            hcnt_reg   <= hcnt_next;
        end
    end

endmodule

// ===== rtl/ipdfx_out_reg.sv =====
// Result register of the IPD frame extractor: holds one result item for the master side.
// Depends on ipdfx_pkg.
module ipdfx_out_reg
    import ipdfx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic in_valid,
    input  res_t in_res,
    output logic free,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? in_valid : (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            res_reg <= in_res;
        end
    end

endmodule

// ===== rtl/ipd_frame_extractor.sv =====
// Top level of the IPD frame extractor: config register, parser and result register.
// Depends on ipdfx_pkg, ipdfx_parser and ipdfx_out_reg.
//
//   channel  | direction | content
//   s_*      | in        | tdata[7:0] data_byte
//   m_*      | out       | tdata[7:0] payload_byte, [23:8] frame_length; tlast is_last;
//            |           | tuser[1:0] status
//   cfg_*    | in        | data[15:0] max_packet_bytes, always ready
//
// The parser state advances on each accepted byte, and its result is captured in the
// result register at that same edge and shows on m_* in the next cycle.
// A new byte is accepted in every cycle unless a held result is stalled by m_tready.
// Reset clears the parse state and sets max_packet_bytes to 1500.
module ipd_frame_extractor
    import ipdfx_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_length
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [LEN_W-1:0] max_pkt_reg;
    logic             step;
    logic             res_valid;
    res_t             res;
    res_t             out_res;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pkt_reg <= LEN_W'(1500);
        end
        else if (cfg_valid)
        begin
            max_pkt_reg <= cfg_data;
        end
    end

    ipdfx_parser #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .data_byte        (s_tdata),
        .max_packet_bytes (max_pkt_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    ipdfx_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .in_valid  (res_valid),
        .in_res    (res),
        .free      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.frame_length, out_res.payload_byte};
    assign m_tlast = out_res.is_last;
    assign m_tuser = out_res.status;

endmodule
